>>> sv/ckwg_pkg.sv
`default_nettype none
package ckwg_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;

  localparam int PHASE_W    = 8;
  localparam int NUM_PHASES = 1 << PHASE_W;
  localparam int NUM_TAPS   = 4;
  localparam int WEIGHT_W   = 18;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = NUM_TAPS * WEIGHT_W;

  localparam int COEF_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int COEF_ONE_RST = 3072;  // 0.75 in Q3.12
  localparam int COEF_TWO_RST = 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_SELECT = 2'd0,
    REG_COEF_ONE      = 2'd1,
    REG_COEF_TWO      = 2'd2
  } reg_idx_t;

  typedef enum logic {
    KERNEL_KEYS     = 1'b0,
    KERNEL_MITCHELL = 1'b1
  } kernel_t;

  // fixed point
  localparam int FRAC_W  = 16;
  localparam int ONE_Q16 = 1 << FRAC_W;
  localparam int ONE_Q12 = 4096;
  localparam int X_W     = FRAC_W + 1;
  localparam int ARG_W   = FRAC_W + 2;
  localparam int U_W     = FRAC_W + 1;
  localparam int CF_W    = 22;

  typedef logic signed [CF_W-1:0] coef_t;

  // Horner accumulators, Q28
  localparam int A1_W  = 40;
  localparam int A1_LO = 20;
  localparam int PL1_W = A1_LO + U_W;
  localparam int PH1_W = A1_W - A1_LO + U_W + 1;
  localparam int S1_W  = A1_W + U_W + 1;
  localparam int A2_W  = 42;
  localparam int A2_LO = 21;
  localparam int PL2_W = A2_LO + U_W;
  localparam int PH2_W = A2_W - A2_LO + U_W + 1;
  localparam int S2_W  = A2_W + U_W + 1;
  localparam int A3_W  = 44;
  localparam int R_W   = A3_W + 1;

  localparam int RND_HALF  = 1 << (FRAC_W - 1);
  localparam int OUT_SHIFT = 14;
  localparam int KEYS_HALF = 1 << (OUT_SHIFT - 1);
  localparam int MN_BIAS   = 3 << OUT_SHIFT;
  localparam int T_W       = R_W - OUT_SHIFT;

  localparam int W_MAX = (1 << (WEIGHT_W - 1)) - 1;
  localparam int W_MIN = -(1 << (WEIGHT_W - 1));

  // floor(t/6) on the offset range by reciprocal multiply
  localparam int MN_SPAN   = 6 * (1 << (WEIGHT_W - 1));
  localparam int TP_W      = 21;
  localparam int RCP_SHIFT = 24;
  localparam int RCP_W     = 22;
  localparam int RECIP6    = ((1 << RCP_SHIFT) + 5) / 6;
  localparam int PROD_W    = TP_W + RCP_W;

  // Mitchell-Netravali polynomial constants
  localparam int MN_IN3  = 12;
  localparam int MN_IN2  = -18;
  localparam int MN_OUT2 = 30;
  localparam int MN_OUT1 = 48;
  localparam int MN_OUT0 = 24;

endpackage
`default_nettype wire

>>> sv/cubic_kernel_weight_generator_top.sv
// Cubic kernel weight generator.
// Input stream: one 8-bit phase index per item on s_axis. The index is
// clamped to TABLE_ENTRIES-1 and mapped to x = index/(TABLE_ENTRIES-1).
// Output stream: four signed Q3.14 weights per item on m_axis, the kernel
// taken at x+1, x, 1-x and 2-x, saturated to 18 bits.
// Config channel: cfg_valid/cfg_index/cfg_data, always ready. Index 0 picks
// the kernel (0 Keys, 1 Mitchell-Netravali), 1 and 2 load coefficients in
// Q3.12. Other indexes are dropped. Write only while no item is in flight.
// Timing: eight register stages: coefficient select, the first Horner step,
// the other two Horner steps each split into a partial-product stage and an
// add stage, then output scaling and the output register. One item per cycle
// is sustained while m_axis_tready is high.
// Stall: every stage has its own valid bit and loads when it is empty or
// its successor moves, so bubbles fill up while m_axis_tready is low and
// s_axis_tready drops only when all eight stages hold items.
// Reset: rst (synchronous) empties the pipeline and loads the Keys kernel
// with A = 0.75 and the second coefficient at zero.
`default_nettype none
module cubic_kernel_weight_generator_top #(
  parameter int TABLE_ENTRIES = ckwg_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ckwg_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] phase_index
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [17:0] weight_far_left, [35:18] weight_near_left,
  // [53:36] weight_near_right, [71:54] weight_far_right
  output logic [ckwg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ckwg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ckwg_pkg::COEF_W-1:0]     cfg_data
);
  import ckwg_pkg::*;

  localparam int LAST = TABLE_ENTRIES - 1;
  localparam int NSTG = 8;

  // configuration
  kernel_t                   kernel_select;
  logic signed [COEF_W-1:0]  coef_one;
  logic signed [COEF_W-1:0]  coef_two;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select <= KERNEL_KEYS;
      coef_one      <= COEF_W'(COEF_ONE_RST);
      coef_two      <= COEF_W'(COEF_TWO_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KERNEL_SELECT: kernel_select <= kernel_t'(cfg_data[0]);
        REG_COEF_ONE:      coef_one      <= cfg_data;
        REG_COEF_TWO:      coef_two      <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase to x, rounded, index clamped
  logic [X_W-1:0] xtab [NUM_PHASES];

  for (genvar g = 0; g < NUM_PHASES; g++) begin : g_xtab
    localparam int IDX = (g > LAST) ? LAST : g;
    localparam int XV  = (2 * IDX * ONE_Q16 + LAST) / (2 * LAST);
    assign xtab[g] = X_W'(XV);
  end

  // stage handshake
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   adv;

  always_comb begin
    adv[NSTG] = m_axis_tready;
    for (int s = NSTG - 1; s >= 0; s--) begin
      adv[s] = !vld[s] || adv[s+1];
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (adv[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // coefficient sets
  coef_t p, q;
  coef_t ki3, ki2, ki0, ko3, ko2, ko1, ko0;
  coef_t mi3, mi2, mi0, mo3, mo2, mo1, mo0;

  assign p = coef_t'(coef_one);
  assign q = coef_t'(coef_two);

  assign ki3 = p + coef_t'(2 * ONE_Q12);
  assign ki2 = -(p + coef_t'(3 * ONE_Q12));
  assign ki0 = coef_t'(ONE_Q12);
  assign ko3 = p;
  assign ko2 = coef_t'(-5) * p;
  assign ko1 = p <<< 3;
  assign ko0 = coef_t'(-4) * p;

  assign mi3 = coef_t'(MN_IN3 * ONE_Q12) - coef_t'(9) * p - coef_t'(6) * q;
  assign mi2 = coef_t'(MN_IN2 * ONE_Q12) + coef_t'(12) * p + coef_t'(6) * q;
  assign mi0 = coef_t'(6 * ONE_Q12) - coef_t'(2) * p;
  assign mo3 = -p - coef_t'(6) * q;
  assign mo2 = coef_t'(6) * p + coef_t'(MN_OUT2) * q;
  assign mo1 = -(coef_t'(12) * p) - coef_t'(MN_OUT1) * q;
  assign mo0 = coef_t'(8) * p + coef_t'(MN_OUT0) * q;

  // stage 0 inputs
  logic [X_W-1:0]   x;
  logic [ARG_W-1:0] arg [NUM_TAPS];
  coef_t            c3_n [NUM_TAPS];
  coef_t            c2_n [NUM_TAPS];
  coef_t            c1_n [NUM_TAPS];
  coef_t            c0_n [NUM_TAPS];

  assign x = xtab[s_axis_tdata[PHASE_W-1:0]];

  always_comb begin
    arg[0] = ARG_W'(x) + ARG_W'(ONE_Q16);
    arg[1] = ARG_W'(x);
    arg[2] = ARG_W'(ONE_Q16) - ARG_W'(x);
    arg[3] = ARG_W'(2 * ONE_Q16) - ARG_W'(x);
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (kernel_select == KERNEL_MITCHELL) begin
        if (arg[k][FRAC_W]) begin
          c3_n[k] = mo3;
          c2_n[k] = mo2;
          c1_n[k] = mo1;
          c0_n[k] = mo0;
        end else begin
          c3_n[k] = mi3;
          c2_n[k] = mi2;
          c1_n[k] = '0;
          c0_n[k] = mi0;
        end
      end else begin
        if (arg[k][FRAC_W]) begin
          c3_n[k] = ko3;
          c2_n[k] = ko2;
          c1_n[k] = ko1;
          c0_n[k] = ko0;
        end else begin
          c3_n[k] = ki3;
          c2_n[k] = ki2;
          c1_n[k] = '0;
          c0_n[k] = ki0;
        end
      end
    end
  end

  // pipeline payload
  logic [U_W-1:0]           u0 [NUM_TAPS];
  logic [U_W-1:0]           u1 [NUM_TAPS];
  logic [U_W-1:0]           u2 [NUM_TAPS];
  logic [U_W-1:0]           u3 [NUM_TAPS];
  logic [NUM_TAPS-1:0]      z0, z1, z2, z3, z4, z5, z6;
  coef_t                    c3_0 [NUM_TAPS];
  coef_t                    c2_0 [NUM_TAPS];
  coef_t                    c1_0 [NUM_TAPS];
  coef_t                    c1_1 [NUM_TAPS];
  coef_t                    c1_2 [NUM_TAPS];
  coef_t                    c0_0 [NUM_TAPS];
  coef_t                    c0_1 [NUM_TAPS];
  coef_t                    c0_2 [NUM_TAPS];
  coef_t                    c0_3 [NUM_TAPS];
  coef_t                    c0_4 [NUM_TAPS];
  logic signed [A1_W-1:0]   acc1 [NUM_TAPS];
  logic [PL1_W-1:0]         pl1 [NUM_TAPS];
  logic signed [PH1_W-1:0]  ph1 [NUM_TAPS];
  logic signed [A2_W-1:0]   acc2 [NUM_TAPS];
  logic [PL2_W-1:0]         pl2 [NUM_TAPS];
  logic signed [PH2_W-1:0]  ph2 [NUM_TAPS];
  logic signed [A3_W-1:0]   acc3 [NUM_TAPS];
  logic signed [WEIGHT_W-1:0] wk6 [NUM_TAPS];
  logic [TP_W-1:0]          tp6 [NUM_TAPS];
  logic [WEIGHT_W-1:0]      w7 [NUM_TAPS];

  // combinational helpers
  logic signed [S1_W-1:0]     sum1 [NUM_TAPS];
  logic signed [S2_W-1:0]     sum2 [NUM_TAPS];
  logic signed [R_W-1:0]      rk [NUM_TAPS];
  logic signed [R_W-1:0]      rm [NUM_TAPS];
  logic signed [T_W-1:0]      tk [NUM_TAPS];
  logic signed [T_W-1:0]      tm [NUM_TAPS];
  logic signed [T_W-1:0]      tmc [NUM_TAPS];
  logic [WEIGHT_W-1:0]        wk_n [NUM_TAPS];
  logic [PROD_W-1:0]          prod [NUM_TAPS];
  logic [WEIGHT_W-1:0]        qm [NUM_TAPS];

  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      sum1[k] = (S1_W'(ph1[k]) <<< A1_LO) + S1_W'($signed({1'b0, pl1[k]}))
                + S1_W'(RND_HALF);
      sum2[k] = (S2_W'(ph2[k]) <<< A2_LO) + S2_W'($signed({1'b0, pl2[k]}))
                + S2_W'(RND_HALF);

      rk[k] = R_W'(acc3[k]) + R_W'(KEYS_HALF);
      rm[k] = R_W'(acc3[k]) + R_W'(MN_BIAS);
      tk[k] = T_W'(rk[k] >>> OUT_SHIFT);
      tm[k] = T_W'(rm[k] >>> OUT_SHIFT);

      if (tk[k] > T_W'(W_MAX)) begin
        wk_n[k] = WEIGHT_W'(W_MAX);
      end else if (tk[k] < T_W'(W_MIN)) begin
        wk_n[k] = WEIGHT_W'(W_MIN);
      end else begin
        wk_n[k] = tk[k][WEIGHT_W-1:0];
      end

      if (tm[k] > T_W'(MN_SPAN - 1)) begin
        tmc[k] = T_W'(MN_SPAN - 1);
      end else if (tm[k] < T_W'(-MN_SPAN)) begin
        tmc[k] = T_W'(-MN_SPAN);
      end else begin
        tmc[k] = tm[k];
      end

      prod[k] = PROD_W'(tp6[k]) * PROD_W'(RECIP6);
      qm[k]   = prod[k][RCP_SHIFT+WEIGHT_W-1:RCP_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (adv[0]) begin
        u0[k]   <= arg[k][U_W-1:0];
        z0[k]   <= arg[k][ARG_W-1];
        c3_0[k] <= c3_n[k];
        c2_0[k] <= c2_n[k];
        c1_0[k] <= c1_n[k];
        c0_0[k] <= c0_n[k];
      end
      if (adv[1]) begin
        acc1[k] <= c3_0[k] * $signed({1'b0, u0[k]})
                   + (A1_W'(c2_0[k]) <<< FRAC_W);
        u1[k]   <= u0[k];
        z1[k]   <= z0[k];
        c1_1[k] <= c1_0[k];
        c0_1[k] <= c0_0[k];
      end
      if (adv[2]) begin
        pl1[k]  <= acc1[k][A1_LO-1:0] * u1[k];
        ph1[k]  <= $signed(acc1[k][A1_W-1:A1_LO]) * $signed({1'b0, u1[k]});
        u2[k]   <= u1[k];
        z2[k]   <= z1[k];
        c1_2[k] <= c1_1[k];
        c0_2[k] <= c0_1[k];
      end
      if (adv[3]) begin
        acc2[k] <= A2_W'(sum1[k] >>> FRAC_W) + (A2_W'(c1_2[k]) <<< FRAC_W);
        u3[k]   <= u2[k];
        z3[k]   <= z2[k];
        c0_3[k] <= c0_2[k];
      end
      if (adv[4]) begin
        pl2[k]  <= acc2[k][A2_LO-1:0] * u3[k];
        ph2[k]  <= $signed(acc2[k][A2_W-1:A2_LO]) * $signed({1'b0, u3[k]});
        z4[k]   <= z3[k];
        c0_4[k] <= c0_3[k];
      end
      if (adv[5]) begin
        acc3[k] <= A3_W'(sum2[k] >>> FRAC_W) + (A3_W'(c0_4[k]) <<< FRAC_W);
        z5[k]   <= z4[k];
      end
      if (adv[6]) begin
        wk6[k] <= wk_n[k];
        tp6[k] <= TP_W'(tmc[k] + T_W'(MN_SPAN));
        z6[k]  <= z5[k];
      end
      if (adv[7]) begin
        if (z6[k]) begin
          w7[k] <= '0;
        end else if (kernel_select == KERNEL_MITCHELL) begin
          w7[k] <= {~qm[k][WEIGHT_W-1], qm[k][WEIGHT_W-2:0]};
        end else begin
          w7[k] <= wk6[k];
        end
      end
    end
  end

  assign m_axis_tdata = {w7[3], w7[2], w7[1], w7[0]};

endmodule
`default_nettype wire

>>> sv/ckwg_checker.sv
`default_nettype none
module ckwg_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ckwg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ckwg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("pipeline not emptied by reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output stage empty");

endmodule

bind cubic_kernel_weight_generator_top ckwg_checker u_ckwg_checker (.*);
`default_nettype wire
